[rtl/amsa_pkg.sv]
// Shared constants, codes and types for the accelerometer shake alarm.
package amsa_pkg;

  localparam int AXIS_W = 16;
  localparam int SQ_W   = 32;
  localparam int MAG_W  = 16;
  localparam int SUM_W  = 23;
  localparam int CNT_W  = 7;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;
  localparam int REM_W  = 9;
  localparam int STAT_W = 2;

  localparam int CAL_SAMPLES_DEFAULT = 100;

  localparam int SQ_STEPS    = 3;
  localparam int SQRT_STEPS  = 16;
  localparam int STEP_W      = $clog2(SQRT_STEPS);

  // shared multiplier: squares and reciprocal divisions
  localparam int MUL_A_W = SUM_W;
  localparam int MUL_B_W = SUM_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // elapsed below 2^16 times ceil(2^25 / 400), shifted right by 25, gives elapsed / 400
  localparam int                 MOD_SHIFT = 25;
  localparam logic [MUL_B_W-1:0] MOD_RECIP = 24'd83887;

  localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 16'd5010;
  localparam logic [CFG_W-1:0]  DURATION_RESET  = 16'd5000;
  localparam logic [MAG_W-1:0]  BASELINE_RESET  = 16'd16384;
  localparam logic [SQ_W-1:0]   SQRT_TOP_BIT    = 32'h4000_0000;
  localparam logic [SQ_W-1:0]   PERIOD_MS       = 32'd400;
  localparam logic [REM_W-1:0]  BUZZ_ON_MS      = 9'd200;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [IDX_W-1:0] REG_DURATION  = 1'd1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_WARN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ALARM = 2'd2;
  localparam logic [STAT_W-1:0] ST_CAL   = 2'd3;

  typedef struct packed {
    logic            ge;
    logic [SQ_W-1:0] diff;
  } cmpsub_res_t;

endpackage

[rtl/amsa_cmpsub.sv]
// Shared 32-bit compare and subtract unit used by the square-root steps and the alarm time arithmetic.
module amsa_cmpsub (
  input  logic [amsa_pkg::SQ_W-1:0] a,
  input  logic [amsa_pkg::SQ_W-1:0] b,
  output amsa_pkg::cmpsub_res_t     res
);

  logic [amsa_pkg::SQ_W:0] wide;

  // borrow out of the wide difference tells a < b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[amsa_pkg::SQ_W];
  assign res.diff = wide[amsa_pkg::SQ_W-1:0];

endmodule

[rtl/accel_magnitude_shake_alarm.sv]
// Top level of the accelerometer shake alarm: sequencer, state and result register.
//
// Each accepted sample is taken in and worked through one shared compare and
// subtract unit under a small sequencer, one sample at a time; in_ready is high
// only while the sequencer is idle. A plain sample passes through squaring on
// the shared multiplier, 16 square-root steps, an evaluation step and the load
// of the result register before the next possible accept. While an alarm runs,
// a sample also needs the elapsed time and its remainder modulo 400 ms: the
// timestamps are subtracted, the difference is multiplied by the reciprocal,
// and the quotient times 400 is subtracted and the result applied. The sample
// that ends calibration divides the magnitude sum by CAL_SAMPLES with the same
// reciprocal multiplication. The result register decouples the output side: a
// new sample is accepted while the previous result waits to be taken, and the
// sequencer holds in its last cycle until the register is free.
module accel_magnitude_shake_alarm #(
  parameter int CAL_SAMPLES = amsa_pkg::CAL_SAMPLES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [amsa_pkg::IDX_W-1:0]        cfg_index,
  input  logic [amsa_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [amsa_pkg::AXIS_W-1:0] accel_x,
  input  logic signed [amsa_pkg::AXIS_W-1:0] accel_y,
  input  logic signed [amsa_pkg::AXIS_W-1:0] accel_z,
  input  logic [amsa_pkg::TIME_W-1:0]       sample_time_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [amsa_pkg::STAT_W-1:0]       status_code,
  output logic [amsa_pkg::MAG_W-1:0]        magnitude_lsb,
  output logic [amsa_pkg::MAG_W-1:0]        deviation_lsb,
  output logic                              buzzer_drive,
  output logic                              alarm_flag
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_TIME  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [amsa_pkg::CNT_W-1:0]  CAL_CNT = amsa_pkg::CNT_W'(CAL_SAMPLES);
  localparam logic [amsa_pkg::STEP_W-1:0] SQ_LAST   = amsa_pkg::STEP_W'(amsa_pkg::SQ_STEPS - 1);
  localparam logic [amsa_pkg::STEP_W-1:0] SQRT_LAST = amsa_pkg::STEP_W'(amsa_pkg::SQRT_STEPS - 1);

  // sum times ceil(2^CAL_SHIFT / CAL_SAMPLES), shifted right by CAL_SHIFT, is the floor average
  localparam int CAL_SHIFT = amsa_pkg::SUM_W + $clog2(CAL_SAMPLES);
  localparam logic [amsa_pkg::MUL_B_W-1:0] CAL_RECIP = amsa_pkg::MUL_B_W'(
    ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  // configuration
  logic [amsa_pkg::CFG_W-1:0] threshold_lsb;
  logic [amsa_pkg::CFG_W-1:0] alarm_duration_ms;

  // block state
  logic [amsa_pkg::CNT_W-1:0]  cal_count;
  logic [amsa_pkg::SUM_W-1:0]  mag_sum;
  logic [amsa_pkg::MAG_W-1:0]  baseline_level;
  logic                        alarm_running;
  logic [amsa_pkg::TIME_W-1:0] alarm_start_ms;
  logic                        buzzer_latch;

  // sequencer and working registers
  logic [2:0]                  state;
  logic [amsa_pkg::STEP_W-1:0] step_cnt;
  logic [amsa_pkg::AXIS_W-1:0] ax, ay, az;
  logic [amsa_pkg::TIME_W-1:0] now_ms;
  logic [amsa_pkg::SQ_W-1:0]   nrem;
  logic [amsa_pkg::SQ_W-1:0]   root;
  logic [amsa_pkg::SQ_W-1:0]   bitv;
  logic [amsa_pkg::SQ_W-1:0]   dvd;
  logic                        div_is_mod;
  logic [amsa_pkg::SQ_W-1:0]   elapsed;
  logic [amsa_pkg::MAG_W-1:0]  dev;
  logic [amsa_pkg::STAT_W-1:0] res_status;

  // combinational helpers
  logic [amsa_pkg::AXIS_W-1:0]   sq_sel;
  logic [amsa_pkg::MUL_A_W-1:0]  mul_a;
  logic [amsa_pkg::MUL_B_W-1:0]  mul_b;
  logic [amsa_pkg::MUL_P_W-1:0]  mul_prod;
  logic [amsa_pkg::SQ_W-1:0]     quot;
  logic [amsa_pkg::SQ_W-1:0]     cs_a, cs_b;
  amsa_pkg::cmpsub_res_t         cs;
  logic [amsa_pkg::MAG_W-1:0]    mag;
  logic [amsa_pkg::MAG_W-1:0]    dev_now;
  logic [amsa_pkg::SUM_W-1:0]    sum_next;
  logic [amsa_pkg::CNT_W-1:0]    cnt_next;
  logic                          trig;
  logic                          expired;
  logic                          calibrating;

  function automatic logic [amsa_pkg::AXIS_W-1:0] abs_axis(
    input logic signed [amsa_pkg::AXIS_W-1:0] v
  );
    logic [amsa_pkg::AXIS_W-1:0] u;
    begin
      u = v;
      abs_axis = u[amsa_pkg::AXIS_W-1] ? (~u + 1'b1) : u;
    end
  endfunction

  amsa_cmpsub u_cmpsub (
    .a   (cs_a),
    .b   (cs_b),
    .res (cs)
  );

  assign in_ready    = (state == S_IDLE);
  assign mag         = root[amsa_pkg::MAG_W-1:0];
  assign calibrating = (cal_count < CAL_CNT);
  assign sum_next    = mag_sum + amsa_pkg::SUM_W'(mag);
  assign cnt_next    = cal_count + 1'b1;
  assign dev_now     = (mag > baseline_level) ? (mag - baseline_level)
                                              : (baseline_level - mag);
  assign trig        = (dev_now > threshold_lsb) && !alarm_running;
  assign expired     = (elapsed > amsa_pkg::SQ_W'(alarm_duration_ms));
  assign quot        = div_is_mod ? amsa_pkg::SQ_W'(mul_prod >> amsa_pkg::MOD_SHIFT)
                                  : amsa_pkg::SQ_W'(mul_prod >> CAL_SHIFT);

  // shared multiplier: squares while squaring, reciprocal otherwise
  always_comb begin
    case (step_cnt[1:0])
      2'd0:    sq_sel = ax;
      2'd1:    sq_sel = ay;
      default: sq_sel = az;
    endcase
    if (state == S_MUL) begin
      // only elapsed times below 2^16 matter: longer ones are past any duration
      mul_a = div_is_mod ? amsa_pkg::MUL_A_W'(dvd[amsa_pkg::CFG_W-1:0])
                         : dvd[amsa_pkg::MUL_A_W-1:0];
      mul_b = div_is_mod ? amsa_pkg::MOD_RECIP : CAL_RECIP;
    end else begin
      mul_a = amsa_pkg::MUL_A_W'(sq_sel);
      mul_b = amsa_pkg::MUL_B_W'(sq_sel);
    end
    mul_prod = amsa_pkg::MUL_P_W'(mul_a) * amsa_pkg::MUL_P_W'(mul_b);
  end

  // operand select for the shared unit
  always_comb begin
    case (state)
      S_SQRT: begin
        cs_a = nrem;
        cs_b = root + bitv;
      end
      S_TIME: begin
        cs_a = now_ms;
        cs_b = alarm_start_ms;
      end
      S_APPLY: begin
        cs_a = elapsed;
        cs_b = dvd * amsa_pkg::PERIOD_MS;
      end
      default: begin
        cs_a = '0;
        cs_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_lsb     <= amsa_pkg::THRESHOLD_RESET;
      alarm_duration_ms <= amsa_pkg::DURATION_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        amsa_pkg::REG_THRESHOLD: threshold_lsb     <= cfg_data;
        amsa_pkg::REG_DURATION:  alarm_duration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step_cnt       <= '0;
      cal_count      <= '0;
      mag_sum        <= '0;
      baseline_level <= amsa_pkg::BASELINE_RESET;
      alarm_running  <= 1'b0;
      alarm_start_ms <= '0;
      buzzer_latch   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax       <= abs_axis(accel_x);
            ay       <= abs_axis(accel_y);
            az       <= abs_axis(accel_z);
            now_ms   <= sample_time_ms;
            nrem     <= '0;
            step_cnt <= '0;
            state    <= S_SQ;
          end
        end
        S_SQ: begin
          nrem <= nrem + mul_prod[amsa_pkg::SQ_W-1:0];
          if (step_cnt == SQ_LAST) begin
            root     <= '0;
            bitv     <= amsa_pkg::SQRT_TOP_BIT;
            step_cnt <= '0;
            state    <= S_SQRT;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (cs.ge) begin
            nrem <= cs.diff;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (step_cnt == SQRT_LAST) begin
            state <= S_EVAL;
          end
          step_cnt <= step_cnt + 1'b1;
        end
        S_EVAL: begin
          step_cnt <= '0;
          if (calibrating) begin
            mag_sum    <= sum_next;
            cal_count  <= cnt_next;
            dev        <= '0;
            res_status <= amsa_pkg::ST_CAL;
            dvd        <= amsa_pkg::SQ_W'(sum_next);
            div_is_mod <= 1'b0;
            state      <= (cnt_next == CAL_CNT) ? S_MUL : S_FIN;
          end else begin
            dev        <= dev_now;
            res_status <= ({dev_now, 1'b0} > {1'b0, threshold_lsb}) ? amsa_pkg::ST_WARN
                                                                     : amsa_pkg::ST_OK;
            if (trig) begin
              alarm_running  <= 1'b1;
              alarm_start_ms <= now_ms;
            end
            state <= (trig || alarm_running) ? S_TIME : S_FIN;
          end
        end
        S_TIME: begin
          elapsed    <= cs.diff;
          dvd        <= cs.diff;
          div_is_mod <= 1'b1;
          state      <= S_MUL;
        end
        S_MUL: begin
          dvd   <= quot;
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (!div_is_mod) begin
            baseline_level <= dvd[amsa_pkg::MAG_W-1:0];
          end else if (expired) begin
            alarm_running <= 1'b0;
            buzzer_latch  <= 1'b0;
          end else begin
            // the shared unit leaves elapsed modulo the period
            buzzer_latch <= (cs.diff[amsa_pkg::REM_W-1:0] < amsa_pkg::BUZZ_ON_MS);
            res_status   <= amsa_pkg::ST_ALARM;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            status_code   <= res_status;
            magnitude_lsb <= mag;
            deviation_lsb <= dev;
            buzzer_drive  <= buzzer_latch;
            alarm_flag    <= alarm_running;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/amsa_checker.sv]
// Port-level checker for the shake alarm and its bind to the top level.
module amsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [amsa_pkg::STAT_W-1:0] status_code,
  input logic [amsa_pkg::MAG_W-1:0]  magnitude_lsb,
  input logic [amsa_pkg::MAG_W-1:0]  deviation_lsb,
  input logic                        buzzer_drive,
  input logic                        alarm_flag
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_code) &&
      $stable(magnitude_lsb) && $stable(deviation_lsb) &&
      $stable(buzzer_drive) && $stable(alarm_flag))
    else $error("result changed while stalled");

  // one sample in work at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while another is in work");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == amsa_pkg::ST_CAL |->
      deviation_lsb == '0 && !buzzer_drive && !alarm_flag)
    else $error("calibration result carries alarm data");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alarm_flag == (status_code == amsa_pkg::ST_ALARM)))
    else $error("alarm flag and status disagree");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && buzzer_drive |-> alarm_flag)
    else $error("buzzer on without alarm");

endmodule

bind accel_magnitude_shake_alarm amsa_checker u_amsa_checker (.*);
